// ----- design/kabf_pkg.sv -----
package kabf_pkg;

    // Arithmetic widths
    localparam int ALU_W   = 38;                    // widest sum or difference
    localparam int MUL_A_W = 36;                    // multiplier operand A (signed)
    localparam int MUL_B_W = 33;                    // multiplier operand B (signed)
    localparam int PROD_W  = MUL_A_W + MUL_B_W;     // exact product
    localparam int PC_W    = 6;

    // Gain divider: quotient bits produced one per cycle
    localparam int QUOT_STEPS = 31;
    localparam int DIV_CNT_W  = $clog2(QUOT_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_TOP = DIV_CNT_W'(QUOT_STEPS - 1);
    localparam logic [31:0] GAIN_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] GAIN_MIN = 32'h8000_0000;

    // Saturation bounds of a 32-bit signed value on the ALU bus
    localparam logic signed [ALU_W-1:0] MAX32 = ALU_W'(32'h7FFF_FFFF);
    localparam logic signed [ALU_W-1:0] MIN32 = ~MAX32;

    // Configuration register indexes
    localparam logic [1:0] CFG_ANGLE_Q = 2'd0;
    localparam logic [1:0] CFG_BIAS_Q  = 2'd1;
    localparam logic [1:0] CFG_MEAS_R  = 2'd2;

    // Reset values of the noise registers (unsigned Q1.30)
    localparam logic [30:0] ANGLE_Q_RST = 31'd1073742;
    localparam logic [30:0] BIAS_Q_RST  = 31'd3221225;
    localparam logic [30:0] MEAS_R_RST  = 31'd32212255;

    // Micro-operations
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_RND16 = 4'd3;
    localparam logic [3:0] OP_RND30 = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_BLE   = 4'd6;
    localparam logic [3:0] OP_JMP   = 4'd7;
    localparam logic [3:0] OP_OUT   = 4'd8;

    // Datapath register codes
    localparam logic [4:0] R_ZERO = 5'd0;
    localparam logic [4:0] R_ANG  = 5'd1;
    localparam logic [4:0] R_BIAS = 5'd2;
    localparam logic [4:0] R_P00  = 5'd3;
    localparam logic [4:0] R_P01  = 5'd4;
    localparam logic [4:0] R_P10  = 5'd5;
    localparam logic [4:0] R_P11  = 5'd6;
    localparam logic [4:0] R_MEAS = 5'd7;
    localparam logic [4:0] R_RATE = 5'd8;
    localparam logic [4:0] R_DT   = 5'd9;
    localparam logic [4:0] R_QA   = 5'd10;
    localparam logic [4:0] R_QB   = 5'd11;
    localparam logic [4:0] R_RM   = 5'd12;
    localparam logic [4:0] R_T    = 5'd13;
    localparam logic [4:0] R_S    = 5'd14;
    localparam logic [4:0] R_X    = 5'd15;
    localparam logic [4:0] R_Y    = 5'd16;
    localparam logic [4:0] R_K0   = 5'd17;
    localparam logic [4:0] R_K1   = 5'd18;

    // One control word of the filter program
    typedef struct packed {
        logic [3:0]      op;
        logic [4:0]      dst;
        logic [4:0]      src_a;
        logic [4:0]      src_b;
        logic            sat;
        logic [PC_W-1:0] target;
    } uword_t;

    function automatic uword_t mk_uword(input logic [3:0] op, input logic [4:0] dst,
                                        input logic [4:0] src_a, input logic [4:0] src_b,
                                        input logic sat, input logic [PC_W-1:0] target);
        uword_t w;
        w.op     = op;
        w.dst    = dst;
        w.src_a  = src_a;
        w.src_b  = src_b;
        w.sat    = sat;
        w.target = target;
        return w;
    endfunction

    // Filter program: predict, gain, update
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            // predict angle
            6'd0:  w = mk_uword(OP_SUB,   R_RATE, R_RATE, R_BIAS, 1'b1, 6'd0);
            6'd1:  w = mk_uword(OP_MUL,   R_ZERO, R_RATE, R_DT,   1'b0, 6'd0);
            6'd2:  w = mk_uword(OP_RND16, R_X,    R_ZERO, R_ZERO, 1'b0, 6'd0);
            6'd3:  w = mk_uword(OP_ADD,   R_ANG,  R_ANG,  R_X,    1'b1, 6'd0);
            // predict covariance
            6'd4:  w = mk_uword(OP_MUL,   R_ZERO, R_P11,  R_DT,   1'b0, 6'd0);
            6'd5:  w = mk_uword(OP_RND16, R_T,    R_ZERO, R_ZERO, 1'b0, 6'd0);
            6'd6:  w = mk_uword(OP_SUB,   R_X,    R_T,    R_P01,  1'b0, 6'd0);
            6'd7:  w = mk_uword(OP_SUB,   R_X,    R_X,    R_P10,  1'b0, 6'd0);
            6'd8:  w = mk_uword(OP_ADD,   R_S,    R_X,    R_QA,   1'b0, 6'd0);
            6'd9:  w = mk_uword(OP_MUL,   R_ZERO, R_S,    R_DT,   1'b0, 6'd0);
            6'd10: w = mk_uword(OP_RND16, R_X,    R_ZERO, R_ZERO, 1'b0, 6'd0);
            6'd11: w = mk_uword(OP_ADD,   R_P00,  R_P00,  R_X,    1'b1, 6'd0);
            6'd12: w = mk_uword(OP_SUB,   R_P01,  R_P01,  R_T,    1'b1, 6'd0);
            6'd13: w = mk_uword(OP_SUB,   R_P10,  R_P10,  R_T,    1'b1, 6'd0);
            6'd14: w = mk_uword(OP_MUL,   R_ZERO, R_QB,   R_DT,   1'b0, 6'd0);
            6'd15: w = mk_uword(OP_RND16, R_X,    R_ZERO, R_ZERO, 1'b0, 6'd0);
            6'd16: w = mk_uword(OP_ADD,   R_P11,  R_P11,  R_X,    1'b1, 6'd0);
            // innovation variance, innovation, gains
            6'd17: w = mk_uword(OP_ADD,   R_S,    R_P00,  R_RM,   1'b0, 6'd0);
            6'd18: w = mk_uword(OP_SUB,   R_Y,    R_MEAS, R_ANG,  1'b1, 6'd0);
            6'd19: w = mk_uword(OP_BLE,   R_ZERO, R_S,    R_ZERO, 1'b0, 6'd23);
            6'd20: w = mk_uword(OP_DIV,   R_K0,   R_P00,  R_S,    1'b0, 6'd0);
            6'd21: w = mk_uword(OP_DIV,   R_K1,   R_P10,  R_S,    1'b0, 6'd0);
            6'd22: w = mk_uword(OP_JMP,   R_ZERO, R_ZERO, R_ZERO, 1'b0, 6'd25);
            6'd23: w = mk_uword(OP_ADD,   R_K0,   R_ZERO, R_ZERO, 1'b0, 6'd0);
            6'd24: w = mk_uword(OP_ADD,   R_K1,   R_ZERO, R_ZERO, 1'b0, 6'd0);
            // update estimates
            6'd25: w = mk_uword(OP_MUL,   R_ZERO, R_K0,   R_Y,    1'b0, 6'd0);
            6'd26: w = mk_uword(OP_RND30, R_X,    R_ZERO, R_ZERO, 1'b0, 6'd0);
            6'd27: w = mk_uword(OP_ADD,   R_ANG,  R_ANG,  R_X,    1'b1, 6'd0);
            6'd28: w = mk_uword(OP_MUL,   R_ZERO, R_K1,   R_Y,    1'b0, 6'd0);
            6'd29: w = mk_uword(OP_RND30, R_X,    R_ZERO, R_ZERO, 1'b0, 6'd0);
            6'd30: w = mk_uword(OP_ADD,   R_BIAS, R_BIAS, R_X,    1'b1, 6'd0);
            // update covariance, bottom row first so the top row stays intact
            6'd31: w = mk_uword(OP_MUL,   R_ZERO, R_K1,   R_P00,  1'b0, 6'd0);
            6'd32: w = mk_uword(OP_RND30, R_X,    R_ZERO, R_ZERO, 1'b0, 6'd0);
            6'd33: w = mk_uword(OP_SUB,   R_P10,  R_P10,  R_X,    1'b1, 6'd0);
            6'd34: w = mk_uword(OP_MUL,   R_ZERO, R_K1,   R_P01,  1'b0, 6'd0);
            6'd35: w = mk_uword(OP_RND30, R_X,    R_ZERO, R_ZERO, 1'b0, 6'd0);
            6'd36: w = mk_uword(OP_SUB,   R_P11,  R_P11,  R_X,    1'b1, 6'd0);
            6'd37: w = mk_uword(OP_MUL,   R_ZERO, R_K0,   R_P00,  1'b0, 6'd0);
            6'd38: w = mk_uword(OP_RND30, R_X,    R_ZERO, R_ZERO, 1'b0, 6'd0);
            6'd39: w = mk_uword(OP_SUB,   R_P00,  R_P00,  R_X,    1'b1, 6'd0);
            6'd40: w = mk_uword(OP_MUL,   R_ZERO, R_K0,   R_P01,  1'b0, 6'd0);
            6'd41: w = mk_uword(OP_RND30, R_X,    R_ZERO, R_ZERO, 1'b0, 6'd0);
            6'd42: w = mk_uword(OP_SUB,   R_P01,  R_P01,  R_X,    1'b1, 6'd0);
            default: w = mk_uword(OP_OUT, R_ZERO, R_ZERO, R_ZERO, 1'b0, 6'd0);
        endcase
        return w;
    endfunction

    // Clamp an ALU value to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [ALU_W-1:0] v);
        logic signed [31:0] r;
        if (v > MAX32) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < MIN32) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- design/kabf_div.sv -----
// Restoring divider for the gains: quot = sat32(trunc(num * 2^30 / den)), den > 0.
// Saturation is decided up front (|num| >= 2*den), so only 31 quotient bits remain.
module kabf_div
    import kabf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic        [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [31:0]           rem_reg;
    logic [31:0]           den_reg;
    logic [QUOT_STEPS-1:0] q_reg;
    logic                  lsb_reg;
    logic                  neg_reg;
    logic signed [31:0]    quot_reg;

    logic [31:0]           mag;
    logic                  sat_hit;
    logic                  next_bit;
    logic [32:0]           trial;
    logic [32:0]           diff;
    logic                  ge;
    logic [31:0]           rem_new;
    logic [QUOT_STEPS-1:0] q_new;
    logic [31:0]           q_ext;

    // Magnitude of the numerator and early saturation test
    always_comb
    begin
        mag     = num[31] ? (~num + 32'd1) : num;
        sat_hit = {1'b0, mag} >= {den, 1'b0};
    end

    // One restoring step: bring down a dividend bit, subtract if it fits
    always_comb
    begin
        next_bit = (cnt_reg == DIV_CNT_TOP) ? lsb_reg : 1'b0;
        trial    = {rem_reg, next_bit};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_new  = ge ? diff[31:0] : trial[31:0];
        q_new    = {q_reg[QUOT_STEPS-2:0], ge};
        q_ext    = {1'b0, q_new};
    end

    // Control: iterate count, done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (sat_hit)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= DIV_CNT_TOP;
                end
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, quotient bits, signed result
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, mag[31:1]};
            lsb_reg <= mag[0];
            neg_reg <= num[31];
            den_reg <= den;
            if (sat_hit)
            begin
                quot_reg <= num[31] ? GAIN_MIN : GAIN_MAX;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_new;
            q_reg   <= q_new;
            if (cnt_reg == '0)
            begin
                quot_reg <= neg_reg ? (~q_ext + 32'd1) : q_ext;
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- design/kalman_angle_bias_filter.sv -----
// Both gain divisions run in turn on the shared restoring divider; when the innovation
// variance is not positive the gains are zeroed without dividing, and a saturating gain
// is settled without iterating. A new item is taken once the last result is loaded;
// a waiting result does not block that, but stalls the next item at its output step.
// Reset (rst_n, async, active low) zeroes angle, bias and covariance and loads the
// default noise registers.
module kalman_angle_bias_filter
    import kabf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] measured_angle,
    input  logic signed [31:0] turn_rate,
    input  logic        [15:0] time_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] filtered_angle,
    output logic signed [31:0] estimated_bias,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_index,
    input  logic        [30:0] cfg_data
);

    // Sequencer
    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            div_wait_reg, div_wait_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_load;
    logic            alu_wr;
    logic            wr_en;
    logic            div_start;
    logic            div_done;
    logic signed [31:0] div_quot;
    uword_t          uw;

    // Filter state and noise registers
    logic signed [31:0] ang_reg, bias_reg;
    logic signed [31:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic        [30:0] qa_reg, qb_reg, rm_reg;

    // Item and scratch registers
    logic signed [31:0] meas_reg, rate_reg;
    logic        [15:0] dt_reg;
    logic signed [32:0] t_reg;
    logic signed [35:0] s_reg, x_reg;
    logic signed [31:0] y_reg, k0_reg, k1_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // Output register
    logic signed [31:0] filtered_angle_reg, estimated_bias_reg;

    // Datapath wires
    logic signed [ALU_W-1:0]   a_val, b_val, alu_res, wval;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic        [PROD_W-1:0]  rnd16, rnd30;

    assign uw = ucode(pc_reg);

    // Operand A select
    always_comb
    begin
        case (uw.src_a)
            R_ANG:   a_val = ALU_W'(ang_reg);
            R_BIAS:  a_val = ALU_W'(bias_reg);
            R_P00:   a_val = ALU_W'(p00_reg);
            R_P01:   a_val = ALU_W'(p01_reg);
            R_P10:   a_val = ALU_W'(p10_reg);
            R_P11:   a_val = ALU_W'(p11_reg);
            R_MEAS:  a_val = ALU_W'(meas_reg);
            R_RATE:  a_val = ALU_W'(rate_reg);
            R_DT:    a_val = ALU_W'(dt_reg);
            R_QA:    a_val = ALU_W'(qa_reg);
            R_QB:    a_val = ALU_W'(qb_reg);
            R_RM:    a_val = ALU_W'(rm_reg);
            R_T:     a_val = ALU_W'(t_reg);
            R_S:     a_val = ALU_W'(s_reg);
            R_X:     a_val = ALU_W'(x_reg);
            R_Y:     a_val = ALU_W'(y_reg);
            R_K0:    a_val = ALU_W'(k0_reg);
            R_K1:    a_val = ALU_W'(k1_reg);
            default: a_val = '0;
        endcase
    end

    // Operand B select
    always_comb
    begin
        case (uw.src_b)
            R_ANG:   b_val = ALU_W'(ang_reg);
            R_BIAS:  b_val = ALU_W'(bias_reg);
            R_P00:   b_val = ALU_W'(p00_reg);
            R_P01:   b_val = ALU_W'(p01_reg);
            R_P10:   b_val = ALU_W'(p10_reg);
            R_P11:   b_val = ALU_W'(p11_reg);
            R_MEAS:  b_val = ALU_W'(meas_reg);
            R_RATE:  b_val = ALU_W'(rate_reg);
            R_DT:    b_val = ALU_W'(dt_reg);
            R_QA:    b_val = ALU_W'(qa_reg);
            R_QB:    b_val = ALU_W'(qb_reg);
            R_RM:    b_val = ALU_W'(rm_reg);
            R_T:     b_val = ALU_W'(t_reg);
            R_S:     b_val = ALU_W'(s_reg);
            R_X:     b_val = ALU_W'(x_reg);
            R_Y:     b_val = ALU_W'(y_reg);
            R_K0:    b_val = ALU_W'(k0_reg);
            R_K1:    b_val = ALU_W'(k1_reg);
            default: b_val = '0;
        endcase
    end

    // Multiplier, registered product
    assign mul_a     = a_val[MUL_A_W-1:0];
    assign mul_b     = b_val[MUL_B_W-1:0];
    assign prod_next = mul_a * mul_b;

    // Round half up, then floor-shift the product
    assign rnd16 = prod_reg + (PROD_W'(1) << 15);
    assign rnd30 = prod_reg + (PROD_W'(1) << 29);

    always_comb
    begin
        case (uw.op)
            OP_ADD:   alu_res = a_val + b_val;
            OP_SUB:   alu_res = a_val - b_val;
            OP_RND16: alu_res = $signed(rnd16[16 +: ALU_W]);
            OP_RND30: alu_res = $signed(rnd30[30 +: ALU_W]);
            default:  alu_res = '0;
        endcase
    end

    // Write-back value: gain from the divider, or ALU result with optional clamp
    always_comb
    begin
        if (uw.op == OP_DIV)
        begin
            wval = ALU_W'(div_quot);
        end
        else if (uw.sat)
        begin
            wval = ALU_W'(sat32(alu_res));
        end
        else
        begin
            wval = alu_res;
        end
    end

    assign alu_wr = uw.op inside {OP_ADD, OP_SUB, OP_RND16, OP_RND30};

    // Step control: advance, branch, wait on divider, hand off result
    always_comb
    begin
        busy_next      = busy_reg;
        pc_next        = pc_reg;
        div_wait_next  = div_wait_reg;
        out_valid_next = out_valid_reg && !out_ready;
        div_start      = 1'b0;
        wr_en          = 1'b0;
        out_load       = 1'b0;
        if (!busy_reg)
        begin
            if (in_valid)
            begin
                busy_next = 1'b1;
                pc_next   = '0;
            end
        end
        else
        begin
            case (uw.op)
                OP_BLE:
                begin
                    if (a_val[ALU_W-1] || (a_val == '0))
                    begin
                        pc_next = uw.target;
                    end
                    else
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                end
                OP_JMP:
                begin
                    pc_next = uw.target;
                end
                OP_DIV:
                begin
                    if (!div_wait_reg)
                    begin
                        div_start     = 1'b1;
                        div_wait_next = 1'b1;
                    end
                    else if (div_done)
                    begin
                        wr_en         = 1'b1;
                        div_wait_next = 1'b0;
                        pc_next       = pc_reg + 1'b1;
                    end
                end
                OP_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_load       = 1'b1;
                        out_valid_next = 1'b1;
                        busy_next      = 1'b0;
                    end
                end
                default:
                begin
                    wr_en   = alu_wr;
                    pc_next = pc_reg + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            div_wait_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            div_wait_reg  <= div_wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Filter state and noise registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ang_reg  <= '0;
            bias_reg <= '0;
            p00_reg  <= '0;
            p01_reg  <= '0;
            p10_reg  <= '0;
            p11_reg  <= '0;
            qa_reg   <= ANGLE_Q_RST;
            qb_reg   <= BIAS_Q_RST;
            rm_reg   <= MEAS_R_RST;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ANGLE_Q: qa_reg <= cfg_data;
                    CFG_BIAS_Q:  qb_reg <= cfg_data;
                    CFG_MEAS_R:  rm_reg <= cfg_data;
                    default:     ;
                endcase
            end
            if (wr_en)
            begin
                case (uw.dst)
                    R_ANG:   ang_reg  <= wval[31:0];
                    R_BIAS:  bias_reg <= wval[31:0];
                    R_P00:   p00_reg  <= wval[31:0];
                    R_P01:   p01_reg  <= wval[31:0];
                    R_P10:   p10_reg  <= wval[31:0];
                    R_P11:   p11_reg  <= wval[31:0];
                    default: ;
                endcase
            end
        end
    end

    // Item capture, scratch registers and product
    always_ff @(posedge clk)
    begin
        if (in_valid && !busy_reg)
        begin
            meas_reg <= measured_angle;
            rate_reg <= turn_rate;
            dt_reg   <= time_step;
        end
        if (wr_en)
        begin
            case (uw.dst)
                R_RATE:  rate_reg <= wval[31:0];
                R_T:     t_reg    <= wval[32:0];
                R_S:     s_reg    <= wval[35:0];
                R_X:     x_reg    <= wval[35:0];
                R_Y:     y_reg    <= wval[31:0];
                R_K0:    k0_reg   <= wval[31:0];
                R_K1:    k1_reg   <= wval[31:0];
                default: ;
            endcase
        end
        if (busy_reg && (uw.op == OP_MUL))
        begin
            prod_reg <= prod_next;
        end
        if (out_load)
        begin
            filtered_angle_reg <= ang_reg;
            estimated_bias_reg <= bias_reg;
        end
    end

    // Gain divider
    kabf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (a_val[31:0]),
        .den   (b_val[31:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign in_ready       = !busy_reg;
    assign out_valid      = out_valid_reg;
    assign filtered_angle = filtered_angle_reg;
    assign estimated_bias = estimated_bias_reg;
    assign cfg_ready      = 1'b1;

endmodule

// ----- design/kabf_checker.sv -----
module kabf_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] filtered_angle,
    input logic signed [31:0] estimated_bias
);

    // Drop input readiness right after a transaction while the item is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input still ready after an accepted transaction");

    // No result can appear in the cycle right after an input transaction
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !$rose(out_valid))
        else $error("result raised immediately after input transaction");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before its transaction");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(filtered_angle) && $stable(estimated_bias)))
        else $error("result payload changed while stalled");

endmodule

bind kalman_angle_bias_filter kabf_checker u_kabf_checker (.*);
